// ===== src/smsk_pkg.sv =====
package smsk_pkg;

  typedef logic              opcode_t;
  typedef logic [1:0]        sid_t;
  typedef logic signed [31:0] word_t;
  typedef logic [1:0]        status_t;

  localparam opcode_t OP_PUSH = 1'b0;
  localparam opcode_t OP_POP  = 1'b1;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;

  localparam word_t UNDERFLOW_VALUE = 32'sh7FFF_FFFF;
  localparam word_t ZERO_WORD       = 32'sh0000_0000;

  typedef struct packed {
    logic load;
    logic step_pop;
    logic done_push;
    logic done_pop;
    logic done_err;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
    logic err;
    logic out_busy;
  } stat_t;

endpackage

// ===== src/smsk_if.sv =====
interface smsk_in_if;
  import smsk_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  sid_t    stack_id;
  word_t   push_value;

  modport source (output valid, output opcode, output stack_id, output push_value,
                  input ready);
  modport sink   (input valid, input opcode, input stack_id, input push_value,
                  output ready);
endinterface

interface smsk_out_if;
  import smsk_pkg::*;

  logic    valid;
  logic    ready;
  word_t   pop_value;
  status_t status;

  modport source (output valid, output pop_value, output status, input ready);
  modport sink   (input valid, input pop_value, input status, output ready);
endinterface

// ===== src/smsk_ctrl.sv =====
module smsk_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  smsk_pkg::stat_t stat,
  output smsk_pkg::cmd_t  cmd
);
  import smsk_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HEAD = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (stat.err) begin
          if (!stat.out_busy) begin
            cmd.done_err = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (stat.is_pop) begin
          cmd.step_pop = 1'b1;
          state_nxt    = S_POP;
        end else if (!stat.out_busy) begin
          cmd.done_push = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_POP: begin
        if (!stat.out_busy) begin
          cmd.done_pop = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/smsk_dp.sv =====
module smsk_dp #(
  parameter int NUM_STACKS = 4,
  parameter int NUM_SLOTS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  smsk_pkg::opcode_t opcode,
  input  smsk_pkg::sid_t    stack_id,
  input  smsk_pkg::word_t   push_value,
  input  smsk_pkg::cmd_t    cmd,
  output smsk_pkg::stat_t   stat,
  input  logic              out_ready,
  output logic              out_valid,
  output smsk_pkg::word_t   pop_value,
  output smsk_pkg::status_t status
);
  import smsk_pkg::*;

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int PW = $clog2(NUM_SLOTS + 1);
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [PW-1:0] NULL_P = PW'(NUM_SLOTS);

  opcode_t        op_r;
  logic [SW-1:0]  sid_r;
  logic           sid_ok_r;
  word_t          val_r;

  logic [PW-1:0]  free_head_r;
  logic [PW-1:0]  hw_r;
  logic [NUM_STACKS-1:0] head_vld_r;

  logic [PW-1:0]  head_mem [NUM_STACKS];
  logic [PW-1:0]  link_mem [NUM_SLOTS];
  word_t          data_mem [NUM_SLOTS];

  logic [PW-1:0]  head_rd_r;
  logic           head_rv_r;
  logic [PW-1:0]  link_rd_r;
  word_t          data_rd_r;
  logic           fresh_r;
  logic [PW-1:0]  fresh_link_r;

  logic           out_valid_r;
  word_t          out_value_r;
  status_t        out_status_r;

  logic [SW-1:0]  sid_in;
  logic [PW-1:0]  top;
  logic [PW-1:0]  link_eff;
  logic           top_null;
  logic           free_null;

  logic           link_we;
  logic [AW-1:0]  link_waddr;
  logic [PW-1:0]  link_wdata;
  logic           link_re;
  logic [AW-1:0]  link_raddr;

  assign sid_in    = SW'(stack_id);
  assign top       = head_rv_r ? head_rd_r : NULL_P;
  assign top_null  = (top >= NULL_P);
  assign free_null = (free_head_r >= NULL_P);
  assign link_eff  = fresh_r ? fresh_link_r : link_rd_r;

  assign stat.is_pop   = (op_r == OP_POP);
  assign stat.err      = !sid_ok_r || ((op_r == OP_POP) ? top_null : free_null);
  assign stat.out_busy = out_valid_r && !out_ready;

  always_comb begin
    link_we    = cmd.done_push || cmd.done_pop;
    link_waddr = cmd.done_push ? free_head_r[AW-1:0] : top[AW-1:0];
    link_wdata = cmd.done_push ? top : free_head_r;
    link_re    = (cmd.load && (opcode == OP_PUSH) && !free_null) || cmd.step_pop;
    link_raddr = cmd.step_pop ? top[AW-1:0] : free_head_r[AW-1:0];
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= opcode;
      sid_r    <= sid_in;
      sid_ok_r <= (32'(stack_id) < NUM_STACKS);
      val_r    <= push_value;
      fresh_r      <= (free_head_r >= hw_r);
      fresh_link_r <= free_head_r + PW'(1);
    end else if (cmd.step_pop) begin
      fresh_r <= 1'b0;
    end
  end

  // head pointer store
  always_ff @(posedge clk) begin
    if (cmd.done_push) begin
      head_mem[sid_r] <= free_head_r;
    end else if (cmd.done_pop) begin
      head_mem[sid_r] <= link_rd_r;
    end
    if (cmd.load) begin
      head_rd_r <= head_mem[sid_in];
      head_rv_r <= head_vld_r[sid_in];
    end
  end

  // link store
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd_r <= link_mem[link_raddr];
    end
  end

  // data store
  always_ff @(posedge clk) begin
    if (cmd.done_push) begin
      data_mem[free_head_r[AW-1:0]] <= val_r;
    end
    if (cmd.step_pop) begin
      data_rd_r <= data_mem[top[AW-1:0]];
    end
  end

  // free list, fill mark, head valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      hw_r        <= '0;
      head_vld_r  <= '0;
    end else if (cmd.done_push) begin
      free_head_r       <= link_eff;
      head_vld_r[sid_r] <= 1'b1;
      if (free_head_r == hw_r) begin
        hw_r <= hw_r + PW'(1);
      end
    end else if (cmd.done_pop) begin
      free_head_r <= top;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.done_push || cmd.done_pop || cmd.done_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done_push) begin
      out_value_r  <= ZERO_WORD;
      out_status_r <= ST_DONE;
    end else if (cmd.done_pop) begin
      out_value_r  <= data_rd_r;
      out_status_r <= ST_DONE;
    end else if (cmd.done_err) begin
      out_value_r  <= (op_r == OP_POP) ? UNDERFLOW_VALUE : ZERO_WORD;
      out_status_r <= (op_r == OP_POP) ? ST_UNDERFLOW : ST_OVERFLOW;
    end
  end

  assign out_valid = out_valid_r;
  assign pop_value = out_value_r;
  assign status    = out_status_r;

endmodule

// ===== src/shared_array_multi_stack.sv =====
// Multiple LIFO stacks sharing one slot store, with a linked free list.
// in_ch: one word per operation (opcode 0 = push, 1 = pop, stack_id,
// push_value). out_ch: exactly one word back per operation, in order, with
// pop_value and status (0 done, 1 overflow, 2 underflow).
// Timing: out_ch.valid is registered; a push, an overflow or an underflow
// is answered from state S_HEAD, a pop from S_HEAD and then S_POP. The pop
// chain is head read, then link and data reads, each from a registered-read
// memory. One operation is in flight at a time; in_ch.ready is high while
// the controller is idle, so a new word is taken even while the previous
// result still waits on out_ch.
// Stall: while out_ch holds an untaken result, the next operation waits in
// its final step with nothing committed until out_ch.ready.
// Reset: all stacks empty, every slot free, result register empty. No
// clearing pass; unwritten links are covered by a fill mark.
module shared_array_multi_stack #(
  parameter int NUM_STACKS = 4,
  parameter int NUM_SLOTS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  smsk_in_if.sink    in_ch,
  smsk_out_if.source out_ch
);
  import smsk_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  smsk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  smsk_dp #(
    .NUM_STACKS (NUM_STACKS),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .opcode     (in_ch.opcode),
    .stack_id   (in_ch.stack_id),
    .push_value (in_ch.push_value),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .pop_value  (out_ch.pop_value),
    .status     (out_ch.status)
  );

endmodule
